FILE: design/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RCB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcb assertion failed");

// next-cycle implication
`define RCB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcb assertion failed");

`endif

FILE: design/rcb_pkg.sv
// package with widths, constants and types of the rc pulse motor drive
`default_nettype none

package rcb_pkg;

   localparam int TICKS_PER_US_DEF = 16;
   localparam int PWM_BITS_DEF     = 10;
   localparam int DUTY_SHIFT_DEF   = 3;

   localparam int WIDTH_W    = 16;
   localparam int SMOOTH_W   = 24;
   localparam int WRAP_W     = 8;
   localparam int DUTY_W     = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] COEF_OLD = 16'd58982;
   localparam logic [12:0] COEF_NEW = 13'd6554;

   localparam logic [16:0]       DUTY_OFFSET = 17'd64;
   localparam logic [DUTY_W-1:0] DUTY_MAX    = 11'd2047;

   localparam int NEUTRAL_US    = 1500;
   localparam int DEAD_BAND_US  = 50;
   localparam int HALF_RANGE_US = 512;
   localparam logic [WRAP_W-1:0] TIMEOUT_RST = 8'd30;
   localparam logic [WRAP_W-1:0] STALE_WRAPS = 8'd2;

   typedef enum logic [1:0] {
      DIR_FWD  = 2'd0,
      DIR_REV  = 2'd1,
      DIR_STOP = 2'd2
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEUTRAL    = 2'd0,
      CSR_DEAD_BAND  = 2'd1,
      CSR_HALF_RANGE = 2'd2,
      CSR_TIMEOUT    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              update;
      dir_type           dir;
      logic [DUTY_W-1:0] duty;
   } decode_type;

   typedef struct packed {
      logic b_high;
      logic b_low;
      logic c_high;
      logic c_low;
   } gate_type;

endpackage

`default_nettype wire

FILE: design/rcb_stream_if.sv
// valid/ready channel interfaces for the rc pulse input and the drive result
`default_nettype none

interface rcb_req_if;
   logic valid;
   logic ready;
   logic rc_level;

   modport source (output valid, output rc_level, input ready);
   modport sink (input valid, input rc_level, output ready);
endinterface

interface rcb_rsp_if;
   logic        valid;
   logic        ready;
   logic        b_high_gate;
   logic        b_low_gate;
   logic        c_high_gate;
   logic        c_low_gate;
   logic        fault_led;
   logic        status_led;
   logic [10:0] drive_level;
   logic [1:0]  motor_direction;

   modport source (output valid, output b_high_gate, output b_low_gate,
                   output c_high_gate, output c_low_gate, output fault_led,
                   output status_led, output drive_level, output motor_direction,
                   input ready);
   modport sink (input valid, input b_high_gate, input b_low_gate,
                 input c_high_gate, input c_low_gate, input fault_led,
                 input status_led, input drive_level, input motor_direction,
                 output ready);
endinterface

`default_nettype wire

FILE: design/rcb_filter.sv
// first-order width filter, 0.9 old plus 0.1 new in q16.8
`default_nettype none

module rcb_filter (
   input  wire logic [rcb_pkg::SMOOTH_W-1:0] smooth,
   input  wire logic [rcb_pkg::WIDTH_W-1:0]  pulse_width,
   output logic      [rcb_pkg::SMOOTH_W-1:0] smooth_next
);
   import rcb_pkg::*;

   logic [39:0] old_prod;
   logic [28:0] new_raw;
   logic [36:0] new_prod;
   logic [39:0] acc;

   assign old_prod    = 40'(smooth) * 40'(COEF_OLD);
   assign new_raw     = 29'(pulse_width) * 29'(COEF_NEW);
   assign new_prod    = {new_raw, 8'd0};
   assign acc         = old_prod + 40'(new_prod);
   assign smooth_next = acc[39:16];

endmodule

`default_nettype wire

FILE: design/rcb_decode.sv
// decodes a filtered width into direction and duty
`default_nettype none

module rcb_decode #(
   parameter int DUTY_SHIFT = rcb_pkg::DUTY_SHIFT_DEF
) (
   input  wire logic [rcb_pkg::WIDTH_W-1:0] pulse_width,
   input  wire logic [rcb_pkg::WIDTH_W-1:0] neutral,
   input  wire logic [rcb_pkg::WIDTH_W-1:0] dead_band,
   input  wire logic [rcb_pkg::WIDTH_W-1:0] half_range,
   output rcb_pkg::decode_type              result
);
   import rcb_pkg::*;

   logic [16:0]        p_plus_h;
   logic [16:0]        n_plus_h;
   logic [16:0]        p_plus_b;
   logic [16:0]        n_plus_b;
   logic               below;
   logic               above;
   logic               rev;
   logic               fwd;
   logic [WIDTH_W-1:0] offset;
   logic [16:0]        scaled;
   logic [DUTY_W-1:0]  duty;

   assign p_plus_h = {1'b0, pulse_width} + {1'b0, half_range};
   assign n_plus_h = {1'b0, neutral} + {1'b0, half_range};
   assign p_plus_b = {1'b0, pulse_width} + {1'b0, dead_band};
   assign n_plus_b = {1'b0, neutral} + {1'b0, dead_band};

   assign below = p_plus_h < {1'b0, neutral};
   assign above = {1'b0, pulse_width} > n_plus_h;
   assign rev   = p_plus_b < {1'b0, neutral};
   assign fwd   = {1'b0, pulse_width} > n_plus_b;

   assign offset = rev ? (neutral - pulse_width) : (pulse_width - neutral);
   assign scaled = {1'b0, offset >> DUTY_SHIFT} + DUTY_OFFSET;
   assign duty   = (scaled > 17'(DUTY_MAX)) ? DUTY_MAX : scaled[DUTY_W-1:0];

   always_comb begin
      result.update = !(below || above);
      if (rev) begin
         result.dir  = DIR_REV;
         result.duty = duty;
      end else if (fwd) begin
         result.dir  = DIR_FWD;
         result.duty = duty;
      end else begin
         result.dir  = DIR_STOP;
         result.duty = '0;
      end
   end

endmodule

`default_nettype wire

FILE: design/rcb_gate.sv
// pwm compare and h-bridge gate pattern
`default_nettype none

module rcb_gate #(
   parameter int PWM_BITS = rcb_pkg::PWM_BITS_DEF
) (
   input  wire logic [rcb_pkg::WIDTH_W-1:0] tick,
   input  wire logic [rcb_pkg::DUTY_W-1:0]  duty,
   input  wire rcb_pkg::dir_type            dir,
   input  wire logic                        timeout,
   output rcb_pkg::gate_type                gates
);
   import rcb_pkg::*;

   logic on;

   assign on = (16'(tick[PWM_BITS-1:0]) < 16'(duty)) && !timeout;

   always_comb begin
      gates = '0;
      case (dir)
         DIR_FWD: begin
            gates.c_high = on;
            gates.b_low  = 1'b1;
         end
         DIR_REV: begin
            gates.b_high = on;
            gates.c_low  = 1'b1;
         end
         default: begin
            gates.c_low = on;
            gates.b_low = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/rc_pulse_brushed_motor_drive_unit.sv
// top level of the rc pulse to brushed motor h-bridge drive
//
//   port      dir   handshake           payload
//   req_ch    in    valid/ready         rc_level, one timer tick per transfer
//   rsp_ch    out   valid/ready         gates, leds, drive_level, motor_direction
//   csr_*     in    write enable only   index 0..3, 16-bit data
//
// one tick per cycle unless rsp_ch stalls; a tick passes the input and result registers
// the path is input register, edge/filter/decode/pwm logic, result register
// synchronous reset clears valid flags and tick state and loads register defaults
// a stalled rsp_ch holds the result; req_ch keeps taking ticks while the result is taken
`default_nettype none
`include "assert_macros.svh"

module rc_pulse_brushed_motor_drive_unit #(
   parameter int TICKS_PER_US = rcb_pkg::TICKS_PER_US_DEF,
   parameter int PWM_BITS     = rcb_pkg::PWM_BITS_DEF,
   parameter int DUTY_SHIFT   = rcb_pkg::DUTY_SHIFT_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rcb_req_if.sink                             req_ch,
   rcb_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_wr_en,
   input  wire logic [rcb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rcb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rcb_pkg::*;

   localparam logic [WIDTH_W-1:0] NEUTRAL_RST    = WIDTH_W'(NEUTRAL_US * TICKS_PER_US);
   localparam logic [WIDTH_W-1:0] DEAD_BAND_RST  = WIDTH_W'(DEAD_BAND_US * TICKS_PER_US);
   localparam logic [WIDTH_W-1:0] HALF_RANGE_RST = WIDTH_W'(HALF_RANGE_US * TICKS_PER_US);

   logic [WIDTH_W-1:0] neutral_ff;
   logic [WIDTH_W-1:0] dead_band_ff;
   logic [WIDTH_W-1:0] half_range_ff;
   logic [WRAP_W-1:0]  timeout_ff;

   logic in_valid_ff;
   logic level_ff;
   logic advance;

   logic [WIDTH_W-1:0]  tick_ff,   tick_in;
   logic [WIDTH_W-1:0]  rise_ff,   rise_in;
   logic                await_ff,  await_in;
   logic                last_ff;
   logic [SMOOTH_W-1:0] smooth_ff, smooth_in;
   logic [WRAP_W-1:0]   wse_ff,    wse_in, wse_mid;
   logic [WRAP_W-1:0]   wsp_ff,    wsp_in, wsp_mid;
   logic [WRAP_W-1:0]   blink_ff,  blink_in;
   dir_type             dir_ff,    dir_in;
   logic [DUTY_W-1:0]   duty_ff,   duty_in;

   logic [SMOOTH_W-1:0] smooth_next;
   decode_type          dec;
   gate_type            gates;
   logic                wrap;
   logic                timeout;
   logic                status;

   logic                rsp_valid_ff;
   gate_type            gates_ff;
   logic                fault_ff;
   logic                status_ff;
   logic [DUTY_W-1:0]   level_out_ff;
   dir_type             dir_out_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         neutral_ff    <= NEUTRAL_RST;
         dead_band_ff  <= DEAD_BAND_RST;
         half_range_ff <= HALF_RANGE_RST;
         timeout_ff    <= TIMEOUT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_NEUTRAL:    neutral_ff    <= csr_wdata;
            CSR_DEAD_BAND:  dead_band_ff  <= csr_wdata;
            CSR_HALF_RANGE: half_range_ff <= csr_wdata;
            CSR_TIMEOUT:    timeout_ff    <= csr_wdata[WRAP_W-1:0];
            default:        timeout_ff    <= timeout_ff;
         endcase
      end
   end

   // input register
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         level_ff <= req_ch.rc_level;
      end
   end

   rcb_filter u_filter (
      .smooth      (smooth_ff),
      .pulse_width (tick_ff - rise_ff),
      .smooth_next (smooth_next)
   );

   rcb_decode #(
      .DUTY_SHIFT (DUTY_SHIFT)
   ) u_decode (
      .pulse_width (smooth_next[SMOOTH_W-1:8]),
      .neutral     (neutral_ff),
      .dead_band   (dead_band_ff),
      .half_range  (half_range_ff),
      .result      (dec)
   );

   always_comb begin
      rise_in   = rise_ff;
      await_in  = await_ff;
      smooth_in = smooth_ff;
      wse_mid   = wse_ff;
      wsp_mid   = wsp_ff;
      dir_in    = dir_ff;
      duty_in   = duty_ff;
      if (level_ff != last_ff) begin
         if (level_ff && !await_ff) begin
            rise_in  = tick_ff;
            await_in = 1'b1;
            wse_mid  = '0;
         end else if (!level_ff && await_ff) begin
            smooth_in = smooth_next;
            await_in  = 1'b0;
            if (wse_ff < STALE_WRAPS) begin
               wsp_mid = '0;
               if (dec.update) begin
                  dir_in  = dec.dir;
                  duty_in = dec.duty;
               end
            end
            wse_mid = '0;
         end
      end
      wrap     = (tick_ff == '1);
      tick_in  = tick_ff + 1'b1;
      wse_in   = (wrap && (wse_mid != '1)) ? wse_mid + 1'b1 : wse_mid;
      wsp_in   = (wrap && (wsp_mid != '1)) ? wsp_mid + 1'b1 : wsp_mid;
      blink_in = wrap ? blink_ff + 1'b1 : blink_ff;
      timeout  = wsp_mid > timeout_ff;
      status   = !timeout && ((duty_in != '0) || blink_ff[WRAP_W-1]);
   end

   rcb_gate #(
      .PWM_BITS (PWM_BITS)
   ) u_gate (
      .tick    (tick_ff),
      .duty    (duty_in),
      .dir     (dir_in),
      .timeout (timeout),
      .gates   (gates)
   );

   // tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         rise_ff   <= '0;
         await_ff  <= 1'b0;
         last_ff   <= 1'b0;
         smooth_ff <= {NEUTRAL_RST, 8'd0};
         wse_ff    <= '0;
         wsp_ff    <= '0;
         blink_ff  <= '0;
         dir_ff    <= DIR_FWD;
         duty_ff   <= '0;
      end else if (advance) begin
         tick_ff   <= tick_in;
         rise_ff   <= rise_in;
         await_ff  <= await_in;
         last_ff   <= level_ff;
         smooth_ff <= smooth_in;
         wse_ff    <= wse_in;
         wsp_ff    <= wsp_in;
         blink_ff  <= blink_in;
         dir_ff    <= dir_in;
         duty_ff   <= duty_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         gates_ff     <= gates;
         fault_ff     <= timeout;
         status_ff    <= status;
         level_out_ff <= duty_in;
         dir_out_ff   <= dir_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.b_high_gate     = gates_ff.b_high;
   assign rsp_ch.b_low_gate      = gates_ff.b_low;
   assign rsp_ch.c_high_gate     = gates_ff.c_high;
   assign rsp_ch.c_low_gate      = gates_ff.c_low;
   assign rsp_ch.fault_led       = fault_ff;
   assign rsp_ch.status_led      = status_ff;
   assign rsp_ch.drive_level     = level_out_ff;
   assign rsp_ch.motor_direction = dir_out_ff;

   // no shoot-through on either leg
   `RCB_ASSERT_IMP(a_no_shoot, clock, reset, rsp_ch.valid,
      !(rsp_ch.b_high_gate && rsp_ch.b_low_gate) && !(rsp_ch.c_high_gate && rsp_ch.c_low_gate))
   // timeout forces high gates and status off
   `RCB_ASSERT_IMP(a_fault_off, clock, reset, rsp_ch.valid && rsp_ch.fault_led,
      !rsp_ch.b_high_gate && !rsp_ch.c_high_gate && !rsp_ch.status_led)
   // stop always carries zero duty
   `RCB_ASSERT_IMP(a_stop_zero, clock, reset, dir_ff == DIR_STOP, duty_ff == '0)
   // a waiting tick with an empty result register is delivered next cycle
   `RCB_ASSERT_NXT(a_flow, clock, reset, in_valid_ff && !rsp_valid_ff, rsp_ch.valid)

endmodule

`default_nettype wire
